[rtl/core/msvf_pkg.sv]
package msvf_pkg;

    localparam int CHANNELS    = 2;
    localparam int CH_W        = 1;
    localparam int SAMPLE_BITS = 24;
    localparam int SAMPLE_MAX  = (2 ** (SAMPLE_BITS - 1)) - 1;

    localparam int NODE_W  = 32;
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 26;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int WIDE_W  = 40;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHELF  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INVD   = 3'd5;

    // Output selection codes
    localparam logic [2:0] MODE_LP    = 3'd0;
    localparam logic [2:0] MODE_BP    = 3'd1;
    localparam logic [2:0] MODE_HP    = 3'd2;
    localparam logic [2:0] MODE_UBP   = 3'd3;
    localparam logic [2:0] MODE_SHELF = 3'd4;
    localparam logic [2:0] MODE_NOTCH = 3'd5;
    localparam logic [2:0] MODE_AP    = 3'd6;
    localparam logic [2:0] MODE_PEAK  = 3'd7;

    typedef struct packed {
        logic [2:0]        mode;
        logic [23:0]       gain;
        logic [21:0]       damp;
        logic signed [23:0] shelf;
        logic [24:0]       invd;
    } t_coef;

    typedef struct packed {
        logic                          start;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [CH_W-1:0]               channel;
    } t_core_req;

    typedef struct packed {
        logic                          busy;
        logic                          done;
        logic signed [SAMPLE_BITS-1:0] y;
    } t_core_rsp;

    function automatic logic signed [NODE_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        if (v > 40'sh007FFFFFFF) begin
            return 32'sh7FFFFFFF;
        end else if (v < -40'sh0080000000) begin
            return -32'sh7FFFFFFF - 32'sd1;
        end
        return NODE_W'(v);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [WIDE_W-1:0] v
    );
        if (v > WIDE_W'(SAMPLE_MAX)) begin
            return SAMPLE_BITS'(SAMPLE_MAX);
        end else if (v < WIDE_W'(-SAMPLE_MAX - 1)) begin
            return SAMPLE_BITS'(-SAMPLE_MAX - 1);
        end
        return SAMPLE_BITS'(v);
    endfunction

endpackage

[rtl/core/msvf_mul.sv]
module msvf_mul (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic signed [msvf_pkg::MUL_A_W-1:0]    i_a,
    input  logic signed [msvf_pkg::MUL_B_W-1:0]    i_b,
    output logic signed [msvf_pkg::PROD_W-1:0]     o_prod
);

    logic signed [msvf_pkg::PROD_W-1:0] r_prod;
    logic signed [msvf_pkg::PROD_W-1:0] n_prod;

    assign n_prod = msvf_pkg::PROD_W'(i_a) * msvf_pkg::PROD_W'(i_b);

    // hold the product while idle so the last term stays readable
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

[rtl/core/msvf_core.sv]
module msvf_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  msvf_pkg::t_core_req  i_req,
    input  msvf_pkg::t_coef      i_coef,
    input  logic                 i_out_free,
    output msvf_pkg::t_core_rsp  o_rsp
);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b000000000001,
        S_HP0_MUL = 12'b000000000010,
        S_HP0_ADD = 12'b000000000100,
        S_HP_MUL  = 12'b000000001000,
        S_HP_ADD  = 12'b000000010000,
        S_BP_MUL  = 12'b000000100000,
        S_BP_ADD  = 12'b000001000000,
        S_LP_MUL  = 12'b000010000000,
        S_LP_ADD  = 12'b000100000000,
        S_UBP_ADD = 12'b001000000000,
        S_AP_ADD  = 12'b010000000000,
        S_FIN     = 12'b100000000000
    } t_state;

    localparam int NW = msvf_pkg::NODE_W;
    localparam int WW = msvf_pkg::WIDE_W;
    localparam int PW = msvf_pkg::PROD_W;

    t_state r_state;
    t_state n_state;

    logic signed [msvf_pkg::SAMPLE_BITS-1:0] r_x;
    logic [msvf_pkg::CH_W-1:0]               r_ch;
    logic signed [NW-1:0] r_hp0, r_hp, r_bp, r_lp, r_ubp, r_u4, r_s1n, r_s2n;
    logic signed [PW-21:0] r_hg, r_bg;

    logic signed [NW-1:0] r_s1 [msvf_pkg::CHANNELS];
    logic signed [NW-1:0] r_s2 [msvf_pkg::CHANNELS];

    logic signed [NW-1:0]           w_s1, w_s2;
    logic                           w_mul_en;
    logic signed [msvf_pkg::MUL_A_W-1:0] w_mul_a;
    logic signed [msvf_pkg::MUL_B_W-1:0] w_mul_b;
    logic signed [PW-1:0]           w_prod;
    logic signed [PW-21:0]          w_p20;
    logic signed [PW-25:0]          w_p24;
    logic signed [NW:0]             w_xs;
    logic signed [PW:0]             w_hp0_sum;
    logic signed [WW-1:0]           w_y_wide;
    logic signed [WW-1:0]           w_x_wide;

    assign w_s1 = r_s1[r_ch];
    assign w_s2 = r_s2[r_ch];

    assign w_p20 = $signed(w_prod[PW-1:20]);
    assign w_p24 = $signed(w_prod[PW-1:24]);

    // x - s2 carries weight 2^20 against the damping product
    assign w_xs      = (NW + 1)'(r_x) - (NW + 1)'(w_s2);
    assign w_hp0_sum = ((PW + 1)'(w_xs) <<< 20) - (PW + 1)'(w_prod);

    always_comb begin
        w_mul_en = 1'b1;
        w_mul_a  = r_bp;
        w_mul_b  = msvf_pkg::MUL_B_W'(i_coef.gain);
        case (r_state)
            S_HP0_MUL: begin
                w_mul_a = w_s1;
                w_mul_b = msvf_pkg::MUL_B_W'({i_coef.damp, 1'b0})
                        + msvf_pkg::MUL_B_W'(i_coef.gain);
            end
            S_HP_MUL: begin
                w_mul_a = r_hp0;
                w_mul_b = msvf_pkg::MUL_B_W'(i_coef.invd);
            end
            S_BP_MUL: begin
                w_mul_a = r_hp;
            end
            S_LP_MUL: begin
                w_mul_a = r_bp;
            end
            S_LP_ADD: begin
                w_mul_b = msvf_pkg::MUL_B_W'({i_coef.damp, 1'b0});
            end
            S_UBP_ADD: begin
                w_mul_b = msvf_pkg::MUL_B_W'({i_coef.damp, 2'b00});
            end
            S_AP_ADD: begin
                w_mul_a = r_ubp;
                w_mul_b = msvf_pkg::MUL_B_W'(i_coef.shelf);
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    msvf_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_req.start) n_state = S_HP0_MUL;
            S_HP0_MUL: n_state = S_HP0_ADD;
            S_HP0_ADD: n_state = S_HP_MUL;
            S_HP_MUL:  n_state = S_HP_ADD;
            S_HP_ADD:  n_state = S_BP_MUL;
            S_BP_MUL:  n_state = S_BP_ADD;
            S_BP_ADD:  n_state = S_LP_MUL;
            S_LP_MUL:  n_state = S_LP_ADD;
            S_LP_ADD:  n_state = S_UBP_ADD;
            S_UBP_ADD: n_state = S_AP_ADD;
            S_AP_ADD:  n_state = S_FIN;
            S_FIN:     if (i_out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // node registers, each formed in one step of the sequence
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_x  <= i_req.sample;
                r_ch <= i_req.channel;
            end
            S_HP0_ADD: r_hp0 <= msvf_pkg::sat32(WW'($signed(w_hp0_sum[PW:20])));
            S_HP_ADD:  r_hp  <= msvf_pkg::sat32(WW'(w_p24));
            S_BP_ADD: begin
                r_bp <= msvf_pkg::sat32(WW'(w_p20) + WW'(w_s1));
                r_hg <= w_p20;
            end
            S_LP_MUL:  r_s1n <= msvf_pkg::sat32(WW'(r_hg) + WW'(r_bp));
            S_LP_ADD: begin
                r_lp <= msvf_pkg::sat32(WW'(w_p20) + WW'(w_s2));
                r_bg <= w_p20;
            end
            S_UBP_ADD: begin
                r_ubp <= msvf_pkg::sat32(WW'(w_p20));
                r_s2n <= msvf_pkg::sat32(WW'(r_bg) + WW'(r_lp));
            end
            S_AP_ADD:  r_u4 <= msvf_pkg::sat32(WW'(w_p20));
            default: ;
        endcase
    end

    // commit the channel's new states as the result leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < msvf_pkg::CHANNELS; i++) begin
                r_s1[i] <= '0;
                r_s2[i] <= '0;
            end
        end else if (r_state == S_FIN && i_out_free) begin
            r_s1[r_ch] <= r_s1n;
            r_s2[r_ch] <= r_s2n;
        end
    end

    assign w_x_wide = WW'(r_x);

    always_comb begin
        case (i_coef.mode)
            msvf_pkg::MODE_LP:    w_y_wide = WW'(r_lp);
            msvf_pkg::MODE_BP:    w_y_wide = WW'(r_bp);
            msvf_pkg::MODE_HP:    w_y_wide = WW'(r_hp);
            msvf_pkg::MODE_UBP:   w_y_wide = WW'(r_ubp);
            msvf_pkg::MODE_SHELF: w_y_wide = w_x_wide + WW'(w_p20);
            msvf_pkg::MODE_NOTCH: w_y_wide = w_x_wide - WW'(r_ubp);
            msvf_pkg::MODE_AP:    w_y_wide = w_x_wide - WW'(r_u4);
            default:              w_y_wide = WW'(r_lp) - WW'(r_hp);
        endcase
    end

    assign o_rsp.busy = (r_state != S_IDLE);
    assign o_rsp.done = (r_state == S_FIN);
    assign o_rsp.y    = msvf_pkg::sat_sample(w_y_wide);

`ifndef SYNTH
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> !(r_state == S_HP0_MUL && $past(r_state) == S_IDLE))
        else $error("sequence restarted while busy");

    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !i_out_free) |=> (r_state == S_FIN))
        else $error("result dropped while output blocked");

    a_state_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !($past(r_state) == S_FIN && $past(i_out_free)) |->
            ($stable(r_s1[0]) && $stable(r_s2[0]) && $stable(r_s1[1]) && $stable(r_s2[1])))
        else $error("integrator state changed outside commit");
`endif

endmodule

[rtl/core/multimode_state_variable_filter_top.sv]
// Multimode state variable filter, two integrators per channel.
//
// Input channel: i_in_valid / o_in_stall carrying i_sample_in (signed Q1.23),
// i_channel and i_last_in. Output channel: o_out_valid / i_out_stall carrying
// o_sample_out (saturated Q1.23) and o_last_out. A beat moves on an edge with
// valid high and stall low. Exactly one output beat follows each input beat.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// ready is always high. Write only while the block is idle.
//
// Enabled: a beat runs through eleven steps of one shared 32x26 multiplier
// and its saturating adder, and the result enters the output register as
// the last step ends; a new beat is taken only once the filter is idle
// again, since the chain of dependent products runs through that multiplier.
// Disabled: the sample goes straight to the output register, one beat per
// cycle while the output drains.
//
// Reset clears the registers to their defaults, empties the output register
// and zeroes every channel's integrator states. A stalled output holds its
// beat; the filter then waits at its last step and input stays stalled.
module multimode_state_variable_filter_top (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_in_valid,
    output logic                                       o_in_stall,
    input  logic signed [msvf_pkg::SAMPLE_BITS-1:0]    i_sample_in,
    input  logic [msvf_pkg::CH_W-1:0]                  i_channel,
    input  logic                                       i_last_in,
    output logic                                       o_out_valid,
    input  logic                                       i_out_stall,
    output logic signed [msvf_pkg::SAMPLE_BITS-1:0]    o_sample_out,
    output logic                                       o_last_out,
    input  logic                                       i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  logic [msvf_pkg::CFG_IDX_W-1:0]             i_cfg_index,
    input  logic [msvf_pkg::CFG_DATA_W-1:0]            i_cfg_data
);

    // configuration registers
    logic        r_enable;
    logic [2:0]  r_mode;
    logic [23:0] r_gain;
    logic [21:0] r_damp;
    logic signed [23:0] r_shelf;
    logic [24:0] r_invd;

    logic r_out_valid;
    logic signed [msvf_pkg::SAMPLE_BITS-1:0] r_sample_out;
    logic r_last_out;
    logic r_last;

    logic w_cfg_we;
    logic w_in_accept;
    logic w_out_free;

    msvf_pkg::t_coef     w_coef;
    msvf_pkg::t_core_req w_req;
    msvf_pkg::t_core_rsp w_rsp;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_mode   <= msvf_pkg::MODE_LP;
            r_gain   <= 24'd1048576;
            r_damp   <= 22'd1048576;
            r_shelf  <= '0;
            r_invd   <= 25'd16777216;
        end else if (w_cfg_we) begin
            unique case (i_cfg_index)
                msvf_pkg::CFG_ENABLE: r_enable <= i_cfg_data[0];
                msvf_pkg::CFG_MODE:   r_mode   <= i_cfg_data[2:0];
                msvf_pkg::CFG_GAIN:   r_gain   <= i_cfg_data[23:0];
                msvf_pkg::CFG_DAMP:   r_damp   <= i_cfg_data[21:0];
                msvf_pkg::CFG_SHELF:  r_shelf  <= $signed(i_cfg_data[23:0]);
                msvf_pkg::CFG_INVD:   r_invd   <= i_cfg_data[24:0];
                default: ;
            endcase
        end
    end

    assign w_coef.mode  = r_mode;
    assign w_coef.gain  = r_gain;
    assign w_coef.damp  = r_damp;
    assign w_coef.shelf = r_shelf;
    assign w_coef.invd  = r_invd;

    // the output register frees up this cycle if empty or being taken
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = w_rsp.busy || !w_out_free;
    assign w_in_accept = i_in_valid && !o_in_stall;

    assign w_req.start   = w_in_accept && r_enable;
    assign w_req.sample  = i_sample_in;
    assign w_req.channel = i_channel;

    msvf_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_coef     (w_coef),
        .i_out_free (w_out_free),
        .o_rsp      (w_rsp)
    );

    // hold the block marker alongside the filter run
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_last <= i_last_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((w_in_accept && !r_enable) || (w_rsp.done && w_out_free)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // bypass beat or filter result; the two never coincide
    always_ff @(posedge i_clk) begin
        if (w_in_accept && !r_enable) begin
            r_sample_out <= i_sample_in;
            r_last_out   <= i_last_in;
        end else if (w_rsp.done && w_out_free) begin
            r_sample_out <= w_rsp.y;
            r_last_out   <= r_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;
    assign o_last_out   = r_last_out;

`ifndef SYNTH
    a_filter_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && r_enable) |=> w_rsp.busy)
        else $error("enabled beat did not start the filter");

    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && !r_enable) |=>
            (r_out_valid && r_sample_out == $past(i_sample_in)))
        else $error("bypass beat not passed through");

    a_mode_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_we && i_cfg_index == msvf_pkg::CFG_MODE) |=>
            (r_mode == $past(i_cfg_data[2:0])))
        else $error("mode write lost");
`endif

endmodule
